@@ rtl/wsd_pkg.sv @@
// types, codes and constants shared by the frame deframer modules
// no dependencies; imported by wsd_step and websocket_client_frame_deframer
package wsd_pkg;

    localparam int unsigned INDEX_WIDTH_DEF = 32;
    localparam logic [31:0] CAP_RESET = 32'd4096;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_CTRL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_BIG  = 2'd3;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'ha;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    localparam logic signed [4:0] OPCODE_NONE = -5'sd1;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD,
        PH_DONE,
        PH_DEAD
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  first_byte;
        logic [3:0]  bytes_left;
        logic [63:0] len_acc;
        logic [31:0] mask_key;
        logic [1:0]  pend_status;
    } frame_state_t;

    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic               frame_done;
        logic [1:0]         status;
        logic signed [4:0]  opcode;
        logic [63:0]        payload_length;
    } result_t;

    localparam frame_state_t STATE_CLEAR = '{
        phase:       PH_HDR0,
        first_byte:  8'd0,
        bytes_left:  4'd0,
        len_acc:     64'd0,
        mask_key:    32'd0,
        pend_status: ST_DATA
    };

endpackage

@@ rtl/wsd_step.sv @@
// per-byte decode step: header checks, length and mask assembly, payload unmasking
// depends on wsd_pkg; instantiated by websocket_client_frame_deframer
module wsd_step
    import wsd_pkg::*;
#(
    parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  frame_state_t           cur_state,
    input  logic [INDEX_WIDTH-1:0] cur_index,
    input  logic [31:0]            out_capacity,
    input  logic [7:0]             byte_in,
    input  logic                   last_byte,
    output frame_state_t           state_next,
    output logic [INDEX_WIDTH-1:0] index_next,
    output result_t                result
);

    localparam logic [63:0] IDX_MAX = (64'd1 << INDEX_WIDTH) - 64'd1;

    frame_state_t           upd;
    logic [INDEX_WIDTH-1:0] upd_index;
    logic                   len_done;
    logic                   hdr_bad;
    logic                   is_ctrl;
    logic [3:0]             op;
    logic [7:0]             mask_byte;

    assign op      = cur_state.first_byte[3:0];
    assign is_ctrl = (upd.first_byte[3:0] inside {OP_PING, OP_PONG});
    assign hdr_bad = (op == OP_CLOSE) || !cur_state.first_byte[7] ||
                     (|cur_state.first_byte[6:4]) ||
                     !(op inside {OP_TEXT, OP_PING, OP_PONG}) || !byte_in[7];

    // next state
    always_comb begin
        upd       = cur_state;
        upd_index = cur_index;
        len_done  = 1'b0;
        case (cur_state.phase)
            PH_HDR0: begin
                upd.first_byte = byte_in;
                upd.phase      = PH_HDR1;
            end
            PH_HDR1: begin
                if (hdr_bad) begin
                    upd.pend_status = ST_BAD;
                    upd.phase       = PH_DEAD;
                end else if (byte_in[6:0] == LEN_EXT16) begin
                    upd.bytes_left = EXT16_BYTES;
                    upd.phase      = PH_EXT;
                end else if (byte_in[6:0] == LEN_EXT64) begin
                    upd.bytes_left = EXT64_BYTES;
                    upd.phase      = PH_EXT;
                end else begin
                    upd.len_acc = {57'd0, byte_in[6:0]};
                    len_done    = 1'b1;
                end
            end
            PH_EXT: begin
                upd.len_acc    = {cur_state.len_acc[55:0], byte_in};
                upd.bytes_left = cur_state.bytes_left - 4'd1;
                len_done       = (upd.bytes_left == 4'd0);
            end
            PH_MASK: begin
                upd.mask_key   = {cur_state.mask_key[23:0], byte_in};
                upd.bytes_left = cur_state.bytes_left - 4'd1;
                if (upd.bytes_left == 4'd0) begin
                    if (out_capacity == 32'd0 ||
                        cur_state.len_acc >= {32'd0, out_capacity}) begin
                        upd.pend_status = ST_BIG;
                        upd.phase       = PH_DEAD;
                    end else if (cur_state.len_acc == 64'd0) begin
                        upd.phase = PH_DONE;
                    end else begin
                        upd.phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                upd_index = cur_index + INDEX_WIDTH'(1);
                if (64'(upd_index) >= cur_state.len_acc) begin
                    upd.phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        if (len_done) begin
            if (upd.len_acc > IDX_MAX || (is_ctrl && upd.len_acc > CTRL_MAX_LEN)) begin
                upd.pend_status = ST_BAD;
                upd.phase       = PH_DEAD;
            end else begin
                upd.phase      = PH_MASK;
                upd.bytes_left = MASK_BYTES;
            end
        end
        if (last_byte) begin
            state_next = STATE_CLEAR;
            index_next = '0;
        end else begin
            state_next = upd;
            index_next = upd_index;
        end
    end

    // mask byte by index mod 4, most significant first
    always_comb begin
        case (cur_index[1:0])
            2'd0:    mask_byte = cur_state.mask_key[31:24];
            2'd1:    mask_byte = cur_state.mask_key[23:16];
            2'd2:    mask_byte = cur_state.mask_key[15:8];
            default: mask_byte = cur_state.mask_key[7:0];
        endcase
    end

    // outputs
    always_comb begin
        result                = '0;
        result.payload_valid  = (cur_state.phase == PH_PAYLOAD);
        result.payload_byte   = result.payload_valid ? (byte_in ^ mask_byte) : 8'd0;
        result.frame_done     = last_byte;
        if (last_byte) begin
            case (upd.phase)
                PH_DEAD: result.status = upd.pend_status;
                PH_DONE: result.status = is_ctrl ? ST_CTRL : ST_DATA;
                default: result.status = ST_BAD;
            endcase
            result.opcode = (cur_state.phase == PH_HDR0) ? OPCODE_NONE
                                                         : {1'b0, upd.first_byte[3:0]};
            result.payload_length = upd.len_acc;
        end
    end

endmodule

@@ rtl/websocket_client_frame_deframer.sv @@
// top level of the client frame deframer: stream ports, state and result registers
// depends on wsd_pkg and wsd_step
//
// raw frame bytes enter on the s_axis channel, one byte per request, with
// s_axis_tlast on the final byte of the frame buffer. every input byte gives
// exactly one result on the m_axis channel. m_axis_tuser flags an unmasked
// payload byte; m_axis_tlast marks the result of the final byte, which also
// carries status, opcode and decoded length. a truncated frame reports
// malformed only on its final byte, so payload already delivered is dropped
// by the consumer.
// the result of an accepted byte is registered and shows in the cycle after
// it. throughput is one byte per cycle while m_axis is not stalled, set by
// the single decode step between the frame state and result registers.
// out_capacity is written via cfg_valid/cfg_data; the user must write it only
// while no frame is in flight, which the block does not enforce. reset sets
// it to 4096 and returns the decoder to the first header byte with no result
// pending. when the receiver stalls, the result holds and s_axis_tready drops
// until taken; a new byte is accepted in the same cycle the held result leaves.
module websocket_client_frame_deframer
    import wsd_pkg::*;
#(
    parameter int unsigned INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // payload_byte, status, opcode, payload_length, pad
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // payload_valid
);

    logic [31:0]            capacity_reg;
    frame_state_t           state_reg;
    frame_state_t           state_next;
    logic [INDEX_WIDTH-1:0] index_reg;
    logic [INDEX_WIDTH-1:0] index_next;
    result_t                result_reg;
    result_t                result_next;
    logic                   m_valid_reg;
    logic                   s_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    wsd_step #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_step (
        .cur_state   (state_reg),
        .cur_index   (index_reg),
        .out_capacity(capacity_reg),
        .byte_in     (s_axis_tdata),
        .last_byte   (s_axis_tlast),
        .state_next  (state_next),
        .index_next  (index_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_CLEAR;
            index_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
                index_reg <= index_next;
            end
            if (s_axis_tready) begin
                m_valid_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = result_reg.payload_valid;
    assign m_axis_tlast  = result_reg.frame_done;
    assign m_axis_tdata  = {1'b0, result_reg.payload_length, result_reg.opcode,
                            result_reg.status, result_reg.payload_byte};

    // frame state clears after the final byte
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_axis_tlast |=> state_reg.phase == PH_HDR0 && index_reg == '0)
        else $error("frame state not cleared after final byte");

    // payload index stays below the decoded length while unmasking
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_PAYLOAD |-> 64'(index_reg) < state_reg.len_acc)
        else $error("payload index reached frame length in payload phase");

    // frame report fields are zero except on the final result
    a_report_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[79:8] == '0)
        else $error("frame report present on a non-final result");

    // payload byte is zero when not flagged
    a_byte_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("payload byte driven without payload flag");

    // a result leaves before its slot is reused
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result is stalled");

endmodule
